### hw/rtl/tmms_pkg.sv
package tmms_pkg;

  localparam int TICK_W = 15;
  localparam int SPEED_W = 16;
  localparam int HOLD_W = 40;

  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_D = 8'h44;

  // byte_phase codes
  localparam logic [2:0] PHASE_END_CHECK = 3'd2;
  localparam logic [2:0] PHASE_REC_LAST = 3'd5;
  localparam logic [2:0] PHASE_LOAD_CLOSED = 3'd7;

  typedef enum logic [2:0] {
    CMD_BEGIN_LOAD = 3'd0,
    CMD_LOAD_BYTE = 3'd1,
    CMD_WRITE_MOVE = 3'd2,
    CMD_START = 3'd3,
    CMD_OVERRIDE = 3'd4,
    CMD_STOP = 3'd5,
    CMD_TICK = 3'd6,
    CMD_NOP = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_BUSY = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_LOAD_DONE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PLAY = 2'd1,
    PH_SETTLE = 2'd2
  } play_phase_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_EXEC,
    C_SCAN,
    C_CHECK,
    C_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic [TICK_W-1:0] dur;
    logic signed [SPEED_W-1:0] right;
    logic signed [SPEED_W-1:0] left;
  } move_t;

  typedef struct packed {
    logic [6:0] seq_length;
    logic [TICK_W-1:0] duration_ticks;
    logic signed [SPEED_W-1:0] right_speed;
    logic signed [SPEED_W-1:0] left_speed;
    logic [5:0] entry_index;
    logic [7:0] byte_in;
  } item_t;

  typedef struct packed {
    logic [6:0] loaded_count;
    status_t status;
    logic running;
    logic signed [SPEED_W-1:0] right_drive;
    logic signed [SPEED_W-1:0] left_drive;
  } result_t;

endpackage

### hw/rtl/tmms_move_mem.sv
module tmms_move_mem #(
  parameter int DEPTH = 64,
  parameter int ADDR_W = 6
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  tmms_pkg::move_t       wr_data,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output tmms_pkg::move_t       rd_data
);

  tmms_pkg::move_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/tmms_ctrl.sv
module tmms_ctrl #(
  parameter int MOVE_SLOTS = 64,
  parameter int SETTLE_TICKS = 100,
  parameter int ADDR_W = 6,
  parameter int CNT_W = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tmms_pkg::cmd_t        in_cmd,
  input  tmms_pkg::item_t       in_item,
  input  logic                  out_free,
  output logic                  res_valid,
  output tmms_pkg::result_t     res,
  output logic                  mem_we,
  output logic [ADDR_W-1:0]     mem_waddr,
  output tmms_pkg::move_t       mem_wdata,
  output logic                  mem_re,
  output logic [ADDR_W-1:0]     mem_raddr,
  input  tmms_pkg::move_t       mem_rdata
);

  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(MOVE_SLOTS);

  tmms_pkg::ctl_state_t state, state_next;
  tmms_pkg::cmd_t cmd, cmd_next;
  tmms_pkg::item_t item, item_next;
  tmms_pkg::status_t status, status_next;
  tmms_pkg::play_phase_t play_phase, play_phase_next;
  logic [CNT_W-1:0] table_length, table_length_next;
  logic [CNT_W-1:0] load_index, load_index_next;
  logic [CNT_W-1:0] play_index, play_index_next;
  logic [2:0] byte_phase, byte_phase_next;
  logic [tmms_pkg::HOLD_W-1:0] byte_hold, byte_hold_next;
  logic [tmms_pkg::TICK_W-1:0] ticks_left, ticks_left_next;
  logic stop_request, stop_request_next;
  logic signed [tmms_pkg::SPEED_W-1:0] drive_left, drive_left_next;
  logic signed [tmms_pkg::SPEED_W-1:0] drive_right, drive_right_next;

  logic busy, is_end, load_full, start_long, slot_ok, scan_go, exec_scan;
  logic [tmms_pkg::TICK_W-1:0] tick_dec;

  assign busy = play_phase != tmms_pkg::PH_IDLE;
  assign is_end = byte_phase == tmms_pkg::PHASE_END_CHECK && byte_hold[7:0] == tmms_pkg::CH_E
                  && byte_hold[15:8] == tmms_pkg::CH_N && item.byte_in == tmms_pkg::CH_D;
  assign load_full = load_index >= SLOTS;
  assign start_long = 32'(item.seq_length) > 32'(MOVE_SLOTS);
  assign slot_ok = 32'(item.entry_index) < 32'(MOVE_SLOTS);
  assign tick_dec = (ticks_left == '0) ? '0 : ticks_left - 1'b1;
  assign scan_go = play_index < table_length && play_index < SLOTS && !stop_request;

  // commands that end in a table scan for the next move
  assign exec_scan = (!busy && cmd == tmms_pkg::CMD_START)
    || (!busy && cmd == tmms_pkg::CMD_LOAD_BYTE && byte_phase <= tmms_pkg::PHASE_REC_LAST
        && (is_end || (byte_phase == tmms_pkg::PHASE_REC_LAST && load_full)))
    || (cmd == tmms_pkg::CMD_TICK && play_phase == tmms_pkg::PH_PLAY && tick_dec == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      tmms_pkg::C_IDLE:  if (in_valid) state_next = tmms_pkg::C_EXEC;
      tmms_pkg::C_EXEC:  state_next = exec_scan ? tmms_pkg::C_SCAN : tmms_pkg::C_EMIT;
      tmms_pkg::C_SCAN:  state_next = scan_go ? tmms_pkg::C_CHECK : tmms_pkg::C_EMIT;
      tmms_pkg::C_CHECK: state_next = (mem_rdata.dur == '0) ? tmms_pkg::C_SCAN
                                                              : tmms_pkg::C_EMIT;
      tmms_pkg::C_EMIT:  if (out_free) state_next = tmms_pkg::C_IDLE;
      default:           state_next = tmms_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    cmd_next = cmd;
    item_next = item;
    status_next = status;
    play_phase_next = play_phase;
    table_length_next = table_length;
    load_index_next = load_index;
    play_index_next = play_index;
    byte_phase_next = byte_phase;
    byte_hold_next = byte_hold;
    ticks_left_next = ticks_left;
    stop_request_next = stop_request;
    drive_left_next = drive_left;
    drive_right_next = drive_right;
    mem_we = 1'b0;
    mem_waddr = load_index[ADDR_W-1:0];
    mem_wdata = '{dur: {item.byte_in[6:0], byte_hold[39:32]},
                  right: byte_hold[31:16], left: byte_hold[15:0]};
    mem_re = 1'b0;
    mem_raddr = play_index[ADDR_W-1:0];
    in_ready = state == tmms_pkg::C_IDLE;
    res_valid = state == tmms_pkg::C_EMIT && out_free;
    res = '{loaded_count: 7'(table_length), status: status, running: busy,
            right_drive: drive_right, left_drive: drive_left};

    unique case (state)
      tmms_pkg::C_IDLE: begin
        if (in_valid) begin
          cmd_next = in_cmd;
          item_next = in_item;
        end
      end
      tmms_pkg::C_EXEC: begin
        status_next = tmms_pkg::ST_OK;
        unique case (cmd)
          tmms_pkg::CMD_BEGIN_LOAD: begin
            if (busy) begin
              status_next = tmms_pkg::ST_BUSY;
            end else begin
              load_index_next = '0;
              byte_phase_next = '0;
              byte_hold_next = '0;
            end
          end
          tmms_pkg::CMD_LOAD_BYTE: begin
            if (busy) begin
              status_next = tmms_pkg::ST_BUSY;
            end else if (byte_phase > tmms_pkg::PHASE_REC_LAST) begin
              // load closed, byte dropped
            end else if (is_end) begin
              table_length_next = load_index;
              byte_phase_next = tmms_pkg::PHASE_LOAD_CLOSED;
              status_next = tmms_pkg::ST_LOAD_DONE;
              stop_request_next = 1'b0;
              play_index_next = '0;
            end else if (byte_phase < tmms_pkg::PHASE_REC_LAST) begin
              for (int i = 0; i < 5; i++) begin
                if (byte_phase == 3'(i)) byte_hold_next[8*i +: 8] = item.byte_in;
              end
              byte_phase_next = byte_phase + 1'b1;
            end else if (load_full) begin
              table_length_next = SLOTS;
              byte_phase_next = tmms_pkg::PHASE_LOAD_CLOSED;
              status_next = tmms_pkg::ST_TOO_LONG;
              stop_request_next = 1'b0;
              play_index_next = '0;
            end else begin
              mem_we = 1'b1;
              load_index_next = load_index + 1'b1;
              byte_phase_next = '0;
              byte_hold_next = '0;
            end
          end
          tmms_pkg::CMD_WRITE_MOVE: begin
            if (slot_ok) begin
              mem_we = 1'b1;
              mem_waddr = ADDR_W'(item.entry_index);
              mem_wdata = '{dur: item.duration_ticks, right: item.right_speed,
                            left: item.left_speed};
            end
          end
          tmms_pkg::CMD_START: begin
            if (busy) begin
              status_next = tmms_pkg::ST_BUSY;
            end else begin
              if (start_long) begin
                status_next = tmms_pkg::ST_TOO_LONG;
                table_length_next = SLOTS;
              end else begin
                table_length_next = CNT_W'(item.seq_length);
              end
              stop_request_next = 1'b0;
              play_index_next = '0;
            end
          end
          tmms_pkg::CMD_OVERRIDE: stop_request_next = 1'b1;
          tmms_pkg::CMD_STOP: begin
            stop_request_next = 1'b1;
            drive_left_next = '0;
            drive_right_next = '0;
          end
          tmms_pkg::CMD_TICK: begin
            if (play_phase == tmms_pkg::PH_PLAY) begin
              ticks_left_next = tick_dec;
              if (tick_dec == '0) play_index_next = play_index + 1'b1;
            end else if (play_phase == tmms_pkg::PH_SETTLE) begin
              ticks_left_next = tick_dec;
              if (tick_dec == '0) play_phase_next = tmms_pkg::PH_IDLE;
            end
          end
          tmms_pkg::CMD_NOP: ;
          default: ;
        endcase
      end
      tmms_pkg::C_SCAN: begin
        if (scan_go) begin
          mem_re = 1'b1;
        end else begin
          drive_left_next = '0;
          drive_right_next = '0;
          if (SETTLE_TICKS == 0) begin
            play_phase_next = tmms_pkg::PH_IDLE;
            ticks_left_next = '0;
          end else begin
            play_phase_next = tmms_pkg::PH_SETTLE;
            ticks_left_next = tmms_pkg::TICK_W'(SETTLE_TICKS);
          end
        end
      end
      tmms_pkg::C_CHECK: begin
        if (mem_rdata.dur == '0) begin
          play_index_next = play_index + 1'b1;
        end else begin
          drive_left_next = mem_rdata.left;
          drive_right_next = mem_rdata.right;
          ticks_left_next = mem_rdata.dur;
          play_phase_next = tmms_pkg::PH_PLAY;
        end
      end
      tmms_pkg::C_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmms_pkg::C_IDLE;
      status <= tmms_pkg::ST_OK;
      play_phase <= tmms_pkg::PH_IDLE;
      table_length <= '0;
      load_index <= '0;
      play_index <= '0;
      byte_phase <= '0;
      byte_hold <= '0;
      ticks_left <= '0;
      stop_request <= 1'b0;
      drive_left <= '0;
      drive_right <= '0;
    end else begin
      state <= state_next;
      status <= status_next;
      play_phase <= play_phase_next;
      table_length <= table_length_next;
      load_index <= load_index_next;
      play_index <= play_index_next;
      byte_phase <= byte_phase_next;
      byte_hold <= byte_hold_next;
      ticks_left <= ticks_left_next;
      stop_request <= stop_request_next;
      drive_left <= drive_left_next;
      drive_right <= drive_right_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    item <= item_next;
  end

`ifndef ASSERT_OFF
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == tmms_pkg::C_SCAN || state == tmms_pkg::C_CHECK) |-> !mem_we)
    else $error("table write during scan");

  a_play_has_ticks: assert property (@(posedge clk) disable iff (rst)
    (state == tmms_pkg::C_IDLE && play_phase == tmms_pkg::PH_PLAY) |-> ticks_left != '0)
    else $error("playing move with zero ticks left");

  a_play_index_range: assert property (@(posedge clk) disable iff (rst)
    (state == tmms_pkg::C_IDLE && play_phase == tmms_pkg::PH_PLAY)
      |-> play_index < table_length)
    else $error("play index past table length");

  a_byte_phase_code: assert property (@(posedge clk) disable iff (rst)
    byte_phase <= tmms_pkg::PHASE_REC_LAST || byte_phase == tmms_pkg::PHASE_LOAD_CLOSED)
    else $error("bad byte phase");

  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == tmms_pkg::C_CHECK) |-> $past(mem_re))
    else $error("check without table read");
`endif

endmodule

### hw/rtl/timed_motor_move_sequencer.sv
// timed motor move sequencer
// input channel s_*: one command beat per transfer, s_tuser carries the command code,
// s_tdata the operand fields; a beat is taken when s_tvalid and s_tready are high
// output channel m_*: exactly one status beat per command beat, in order, with the
// drive values, running flag, status code and table length after that command
// moves live in a single-port-write, registered-read table of MOVE_SLOTS entries;
// a start, a completed load, or a tick that ends a move scans the table from the
// play index, reading and then checking each entry, skipping zero durations
// a result passes the EXEC and EMIT states and then the output register; a scan adds
// a SCAN and a CHECK state per entry it looks at, plus a final SCAN when it finds
// no move (up to MOVE_SLOTS entries looked at)
// one command is in flight at a time, scans included; the next beat is taken as soon
// as the result moves to the output register, so s_tready returns while m_tvalid
// still waits
// a stalled receiver (m_tready low) holds m_tdata; a second finished result waits
// inside the controller until the output register frees up
// reset (rst, synchronous): playback idle, drive zero, table length zero, byte
// load open at the first record; the table contents stay undefined until written
module timed_motor_move_sequencer #(
  parameter int MOVE_SLOTS = 64,
  parameter int SETTLE_TICKS = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [2:0]  s_tuser,   // cmd
  // byte_in, entry_index, left_speed, right_speed, duration_ticks, seq_length, pad
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // left_drive, right_drive, running, status, loaded_count, pad
  output logic [47:0] m_tdata
);

  // table address and counter widths follow the slot count
  localparam int ADDR_W = (MOVE_SLOTS > 1) ? $clog2(MOVE_SLOTS) : 1;
  localparam int CNT_W = $clog2(MOVE_SLOTS + 1);

  tmms_pkg::item_t item;
  tmms_pkg::result_t res;
  tmms_pkg::move_t mem_wdata, mem_rdata;
  logic res_valid, out_free, mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;

  assign item = tmms_pkg::item_t'(s_tdata[67:0]);

  // output register frees when empty or drained this cycle
  assign out_free = !m_tvalid || m_tready;

  tmms_ctrl #(
    .MOVE_SLOTS  (MOVE_SLOTS),
    .SETTLE_TICKS(SETTLE_TICKS),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (tmms_pkg::cmd_t'(s_tuser)),
    .in_item  (item),
    .out_free (out_free),
    .res_valid(res_valid),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  tmms_move_mem #(
    .DEPTH (MOVE_SLOTS),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {6'b0, res};
    end
  end

endmodule
